// ===== rtl/escape_time_fractal_iterator_assert.svh =====
// ----------------------------------------------------------------------------
// Escape-time iterator assertion macros
// Property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define ETF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("etf assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define ETF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("etf assertion failed");

// Next-cycle implication, always checked (used for reset behavior).
`define ETF_ASSERT_NEXT_NORST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("etf assertion failed");

`endif

// ===== rtl/etf_pkg.sv =====
// ----------------------------------------------------------------------------
// etf_pkg
// Shared constants and types of the escape-time iterator.
// ----------------------------------------------------------------------------
package etf_pkg;

    // max_iterations register width
    localparam int MAXIT_W = 16;

    // configuration register indexes
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  CFG_MAX_ITER = 2'd0;
    localparam logic [1:0]  CFG_C_REAL   = 2'd1;
    localparam logic [1:0]  CFG_C_IMAG   = 2'd2;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/etf_in_if.sv =====
// ----------------------------------------------------------------------------
// etf_in_if
// Starting point channel: valid/ready plus the two coordinates.
// ----------------------------------------------------------------------------
interface etf_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_real;
    logic signed [COORD_WIDTH-1:0] start_imag;

    modport source (output valid, output start_real, output start_imag, input ready);
    modport sink   (input valid, input start_real, input start_imag, output ready);
endinterface

// ===== rtl/etf_out_if.sv =====
// ----------------------------------------------------------------------------
// etf_out_if
// Result channel: valid/ready plus the iteration count.
// ----------------------------------------------------------------------------
interface etf_out_if #(
    parameter int COUNT_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] iteration_count;

    modport source (output valid, output iteration_count, input ready);
    modport sink   (input valid, input iteration_count, output ready);
endinterface

// ===== rtl/etf_mul.sv =====
// ----------------------------------------------------------------------------
// etf_mul
// Three-stage fixed-point multiplier: magnitudes, two half-width partial
// products, then sum, shift by FRAC_BITS (toward zero) and saturate.
// ----------------------------------------------------------------------------
module etf_mul #(
    parameter int CW        = 32,
    parameter int FRAC_BITS = 28
) (
    input  logic                 i_clk,
    input  logic signed [CW-1:0] i_a,
    input  logic signed [CW-1:0] i_b,
    output logic signed [CW-1:0] o_p
);
    localparam int LO = CW / 2;
    localparam int HI = CW - LO;
    localparam int PW = 2 * CW;
    localparam int MW = 2 * CW + 1;
    localparam int EW = MW + FRAC_BITS;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic [CW-1:0]    abs_a;
    logic [CW-1:0]    abs_b;
    logic [CW-1:0]    r_ma;
    logic [CW-1:0]    r_mb;
    logic             r_neg1;
    logic [CW+LO-1:0] r_pl;
    logic [CW+HI-1:0] r_ph;
    logic             r_neg2;
    logic [PW-1:0]    prod;
    logic [EW-1:0]    prod_ext;
    logic [MW-1:0]    mag;
    logic             pos_ovf;
    logic             neg_ovf;
    logic signed [CW-1:0] n_p;
    logic signed [CW-1:0] r_p;

    assign abs_a = i_a[CW-1] ? ((~i_a) + CW'(1)) : i_a;
    assign abs_b = i_b[CW-1] ? ((~i_b) + CW'(1)) : i_b;

    always_ff @(posedge i_clk) begin
        r_ma   <= abs_a;
        r_mb   <= abs_b;
        r_neg1 <= i_a[CW-1] ^ i_b[CW-1];
        r_pl   <= r_ma * r_mb[LO-1:0];
        r_ph   <= r_ma * r_mb[CW-1:LO];
        r_neg2 <= r_neg1;
        r_p    <= n_p;
    end

    assign prod     = PW'(r_pl) + (PW'(r_ph) << LO);
    assign prod_ext = EW'(prod);
    assign mag      = prod_ext[EW-1:FRAC_BITS];
    assign pos_ovf  = |mag[MW-1:CW-1];
    // magnitude 2^(CW-1) still fits on the negative side
    assign neg_ovf  = (|mag[MW-1:CW]) || (mag[CW-1] && (|mag[CW-2:0]));

    always_comb begin
        if (!r_neg2) begin
            n_p = pos_ovf ? CMAX : mag[CW-1:0];
        end else begin
            n_p = neg_ovf ? CMIN : ((~mag[CW-1:0]) + CW'(1));
        end
    end

    assign o_p = r_p;
endmodule

// ===== rtl/etf_queue.sv =====
// ----------------------------------------------------------------------------
// etf_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module etf_queue #(
    parameter int W = 80
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [W-1:0]         i_data,
    input  logic                 i_pop,
    output logic [W-1:0]         o_data,
    output etf_pkg::t_qstat      o_stat
);
    localparam int QW = (etf_pkg::QUEUE_DEPTH > 1) ? $clog2(etf_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(etf_pkg::QUEUE_DEPTH + 1);
    localparam logic [QW-1:0] LAST = QW'(etf_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULLCNT = CW'(etf_pkg::QUEUE_DEPTH);

    logic [W-1:0]  r_mem [etf_pkg::QUEUE_DEPTH];
    logic [QW-1:0] r_wr;
    logic [QW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + QW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + QW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == FULLCNT);
    assign o_stat.empty = (r_cnt == '0);
endmodule

// ===== rtl/etf_front.sv =====
// ----------------------------------------------------------------------------
// etf_front
// Accepts starting points, clamps the iteration bound, queues the job.
// ----------------------------------------------------------------------------
module etf_front #(
    parameter int CW   = 32,
    parameter int CNTW = 16
) (
    etf_in_if.sink                      i_pt,
    input  logic [etf_pkg::MAXIT_W-1:0] i_max_iter,
    input  etf_pkg::t_qstat             i_qstat,
    output logic                        o_push,
    output logic [CNTW+2*CW-1:0]        o_job
);
    localparam int LW = (CNTW > etf_pkg::MAXIT_W) ? CNTW : etf_pkg::MAXIT_W;
    localparam logic [LW-1:0] CNT_MAX = LW'({CNTW{1'b1}});

    logic [LW-1:0]   mi_ext;
    logic [CNTW-1:0] lim;

    assign mi_ext = LW'(i_max_iter);
    // bound above the count range saturates to all ones
    assign lim    = (mi_ext > CNT_MAX) ? {CNTW{1'b1}} : mi_ext[CNTW-1:0];

    assign i_pt.ready = !i_qstat.full;
    assign o_push     = i_pt.valid && !i_qstat.full;
    assign o_job      = {lim, i_pt.start_imag, i_pt.start_real};
endmodule

// ===== rtl/etf_back.sv =====
// ----------------------------------------------------------------------------
// etf_back
// Iteration engine: a 13-step sequence per iteration on one shared
// pipelined multiplier, and the result output register.
// ----------------------------------------------------------------------------
module etf_back #(
    parameter int CW        = 32,
    parameter int FRAC_BITS = 28,
    parameter int CNTW      = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  etf_pkg::t_qstat        i_qstat,
    input  logic [CNTW+2*CW-1:0]   i_job,
    output logic                   o_pop,
    input  logic signed [CW-1:0]   i_c_real,
    input  logic signed [CW-1:0]   i_c_imag,
    etf_out_if.source              o_res
);
    localparam int EW = CW + FRAC_BITS + 3;
    localparam logic [EW-1:0] FOUR = EW'(1) << (FRAC_BITS + 2);
    localparam logic signed [CW-1:0]   CMAX   = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0]   CMIN   = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW+1:0]   CMAX_X = {2'b00, CMAX};
    localparam logic signed [CW+1:0]   CMIN_X = {2'b11, CMIN};

    // step codes within one iteration
    localparam logic [3:0] ST_ISSUE_RR = 4'd0;
    localparam logic [3:0] ST_ISSUE_II = 4'd1;
    localparam logic [3:0] ST_ISSUE_IR = 4'd2;
    localparam logic [3:0] ST_TAKE_RR  = 4'd3;
    localparam logic [3:0] ST_TAKE_II  = 4'd4;
    localparam logic [3:0] ST_ESCAPE   = 4'd5;
    localparam logic [3:0] ST_TAKE_X   = 4'd8;
    localparam logic [3:0] ST_ISSUE_NI = 4'd9;
    localparam logic [3:0] ST_UPDATE   = 4'd12;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [3:0]           r_step;
    logic [CNTW-1:0]      r_cnt;
    logic [CNTW-1:0]      r_lim;
    logic signed [CW-1:0] r_zr;
    logic signed [CW-1:0] r_zi;
    logic signed [CW-1:0] r_rr;
    logic signed [CW-1:0] r_ii;
    logic signed [CW-1:0] r_nr;
    logic                 r_out_valid;
    logic [CNTW-1:0]      r_out_cnt;

    logic signed [CW-1:0] mul_a;
    logic signed [CW-1:0] mul_b;
    logic signed [CW-1:0] mul_p;
    logic [CW:0]          esc_sum;
    logic                 escape;
    logic signed [CW+1:0] nr_sum;
    logic signed [CW+1:0] ni_sum;

    function automatic logic signed [CW-1:0] sat_w(input logic signed [CW+1:0] v);
        logic signed [CW-1:0] r;
        if (v > CMAX_X) begin
            r = CMAX;
        end else if (v < CMIN_X) begin
            r = CMIN;
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    etf_mul #(
        .CW        (CW),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        case (r_step)
            ST_ISSUE_II: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            ST_ISSUE_IR: begin
                mul_a = r_zi;
                mul_b = r_zr;
            end
            ST_ESCAPE: begin
                // (zi*zr) arrives now and goes straight back in with zi
                mul_a = mul_p;
                mul_b = r_zi;
            end
            ST_ISSUE_NI: begin
                mul_a = r_nr;
                mul_b = r_zr;
            end
            default: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
        endcase
    end

    // squares are never negative, so the sum is taken unsigned
    assign esc_sum = {1'b0, r_rr} + {1'b0, r_ii};
    assign escape  = {{(EW-CW-1){1'b0}}, esc_sum} >= FOUR;
    assign nr_sum  = {{2{r_rr[CW-1]}}, r_rr} - {{2{mul_p[CW-1]}}, mul_p}
                   + {{2{i_c_real[CW-1]}}, i_c_real};
    assign ni_sum  = {{2{mul_p[CW-1]}}, mul_p} + {{2{i_c_imag[CW-1]}}, i_c_imag};

    assign o_pop = (r_state == S_IDLE) && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_ISSUE_RR;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE reloads the output register on its own
            if (r_out_valid && o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_zr    <= i_job[CW-1:0];
                        r_zi    <= i_job[2*CW-1:CW];
                        r_lim   <= i_job[CNTW+2*CW-1:2*CW];
                        r_cnt   <= '0;
                        r_step  <= ST_ISSUE_RR;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    case (r_step)
                        ST_ISSUE_RR: begin
                            if (r_cnt == r_lim) begin
                                r_state <= S_DONE;
                            end else begin
                                r_step <= r_step + 4'd1;
                            end
                        end
                        ST_TAKE_RR: begin
                            r_rr   <= mul_p;
                            r_step <= r_step + 4'd1;
                        end
                        ST_TAKE_II: begin
                            r_ii   <= mul_p;
                            r_step <= r_step + 4'd1;
                        end
                        ST_ESCAPE: begin
                            if (escape) begin
                                r_state <= S_DONE;
                            end else begin
                                r_step <= r_step + 4'd1;
                            end
                        end
                        ST_TAKE_X: begin
                            r_nr   <= sat_w(nr_sum);
                            r_step <= r_step + 4'd1;
                        end
                        ST_UPDATE: begin
                            r_zr   <= r_nr;
                            r_zi   <= sat_w(ni_sum);
                            r_cnt  <= r_cnt + CNTW'(1);
                            r_step <= ST_ISSUE_RR;
                        end
                        default: begin
                            r_step <= r_step + 4'd1;
                        end
                    endcase
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_cnt   <= r_cnt;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.iteration_count = r_out_cnt;
endmodule

// ===== rtl/escape_time_fractal_iterator.sv =====
// Flow: an accepted point is queued and taken by the back end once it is
//   idle; the bound check or the escape test ends its run, and its count
//   is registered. The back end runs one item at a time, paced by the
//   13-step iteration sequence on the single three-stage multiplier.
// Reset: synchronous, clears queue, sequencer and output valid; configuration
//   returns to max_iterations = 64 and c = 0.84 + 0.31i. No clearing pass.
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Julia-style escape-time iteration count for one starting point per item.
// ----------------------------------------------------------------------------
//
// Structure
//   etf_front : takes the starting point, clamps the bound to the count range,
//               pushes a job into the queue.
//   etf_queue : two-entry job FIFO; the front keeps accepting while the back
//               is busy, until the queue is full.
//   etf_back  : runs the iteration on one shared multiplier and holds the
//               result in an output register, so the next job can start
//               while a finished count still waits for its transfer.
//
// Per iteration (steps 0..12):
//   0..2  issue zr*zr, zi*zi, zi*zr
//   0     bound check, 5 escape check (zr^2 + zi^2 >= 4)
//   5     issue (zi*zr)*zi, 8 form new real part (saturated)
//   9     issue new_r*zr, 12 form new imag part and advance
//
// Configuration writes are only expected while idle.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    etf_in_if.sink                        i_pt,
    etf_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [etf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data
);
    localparam int JW = COUNT_WIDTH + 2 * COORD_WIDTH;

    // rounded Q-format values of 0.84 and 0.31
    localparam logic [63:0] C_REAL_RST64 = ((64'd84 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] C_IMAG_RST64 = ((64'd31 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [etf_pkg::MAXIT_W-1:0] MAXIT_RST = etf_pkg::MAXIT_W'(64);

    logic [etf_pkg::MAXIT_W-1:0]  r_max_iter;
    logic signed [COORD_WIDTH-1:0] r_c_real;
    logic signed [COORD_WIDTH-1:0] r_c_imag;

    logic                  q_push;
    logic [JW-1:0]         q_in;
    logic                  q_pop;
    logic [JW-1:0]         q_out;
    etf_pkg::t_qstat       q_stat;

    // register bank; indexes outside the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAXIT_RST;
            r_c_real   <= C_REAL_RST64[COORD_WIDTH-1:0];
            r_c_imag   <= C_IMAG_RST64[COORD_WIDTH-1:0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                etf_pkg::CFG_MAX_ITER: r_max_iter <= i_cfg_data[etf_pkg::MAXIT_W-1:0];
                etf_pkg::CFG_C_REAL:   r_c_real   <= i_cfg_data;
                etf_pkg::CFG_C_IMAG:   r_c_imag   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    etf_front #(
        .CW   (COORD_WIDTH),
        .CNTW (COUNT_WIDTH)
    ) u_front (
        .i_pt       (i_pt),
        .i_max_iter (r_max_iter),
        .i_qstat    (q_stat),
        .o_push     (q_push),
        .o_job      (q_in)
    );

    etf_queue #(
        .W (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    etf_back #(
        .CW        (COORD_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .CNTW      (COUNT_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (q_stat),
        .i_job    (q_out),
        .o_pop    (q_pop),
        .i_c_real (r_c_real),
        .i_c_imag (r_c_imag),
        .o_res    (o_res)
    );
endmodule

// ===== rtl/etf_chk.sv =====
// ----------------------------------------------------------------------------
// etf_chk
// Port-level checker for the escape-time iterator, bound to the top level.
// ----------------------------------------------------------------------------
`include "escape_time_fractal_iterator_assert.svh"

module etf_chk #(
    parameter int COUNT_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [COUNT_WIDTH-1:0] i_out_count
);
    logic       in_xfer;
    logic       out_xfer;
    logic [2:0] r_pend;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'd0;
        end else if (in_xfer && !out_xfer) begin
            r_pend <= r_pend + 3'd1;
        end else if (out_xfer && !in_xfer) begin
            r_pend <= r_pend - 3'd1;
        end
    end

    `ETF_ASSERT_NEXT_NORST(a_rst_clears_valid, i_clk, !i_rst_n, !i_out_valid)
    `ETF_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `ETF_ASSERT_NEXT(a_count_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_count))
    `ETF_ASSERT_SAME(a_no_extra_result, i_clk, i_rst_n, out_xfer, r_pend != 3'd0)
    `ETF_ASSERT_SAME(a_bounded_inflight, i_clk, i_rst_n, in_xfer, r_pend <= 3'd3)
endmodule

bind escape_time_fractal_iterator etf_chk #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_etf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_count (o_res.iteration_count)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Escape-time iterator testbench
// Feeds starting points through the valid/ready point channel, predicts each
// iteration count with an independent fixed-point model of the update, and
// checks every count transfer in order. Register settings change between
// phases while the block is idle; most phases stall both channels at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = 32;
    localparam int FRAC    = 28;
    localparam int CNT_W   = 16;

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam longint FOUR      = 64'sd4 <<< FRAC;
    localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;

    // index 3 is decoded by nothing; writes to it must be dropped
    localparam logic [etf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // handy Q4.28 values
    localparam logic signed [COORD_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] Q_TWO   = 32'sh2000_0000;
    localparam logic signed [COORD_W-1:0] Q_ONE   = 32'sh1000_0000;
    localparam logic signed [COORD_W-1:0] Q_HALF  = 32'sh0800_0000;
    localparam logic signed [COORD_W-1:0] Q_QUART = 32'sh0400_0000;
    localparam logic [COORD_W-1:0] C_REAL_RST = 32'd225485783;
    localparam logic [COORD_W-1:0] C_IMAG_RST = 32'd83214991;

    typedef struct packed {
        logic signed [COORD_W-1:0] re;
        logic signed [COORD_W-1:0] im;
    } t_point;

    // ------------------------------------------------------------------------
    // Clock, reset and locally held drive values (known from time zero)
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    logic                      drv_valid = 1'b0;
    logic signed [COORD_W-1:0] drv_re    = '0;
    logic signed [COORD_W-1:0] drv_im    = '0;
    logic                      res_ready = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [etf_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [COORD_W-1:0]        cfg_data  = '0;

    etf_in_if  #(.COORD_WIDTH(COORD_W)) pt_if ();
    etf_out_if #(.COUNT_WIDTH(CNT_W))   res_if ();

    assign pt_if.valid      = drv_valid;
    assign pt_if.start_real = drv_re;
    assign pt_if.start_imag = drv_im;
    assign res_if.ready     = res_ready;

    escape_time_fractal_iterator #(
        .COORD_WIDTH(COORD_W),
        .FRAC_BITS  (FRAC),
        .COUNT_WIDTH(CNT_W)
    ) uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_pt      (pt_if),
        .o_res     (res_if),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow of the register file, kept by the sequence that writes it
    // ------------------------------------------------------------------------
    int unsigned cfg_bound  = 64;
    longint      cfg_c_real = 64'sd225485783;
    longint      cfg_c_imag = 64'sd83214991;

    // ------------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------------
    t_point           pending_points[$];
    logic [CNT_W-1:0] expected_counts[$];
    t_point           next_pt;
    logic             pt_taken      = 1'b0;
    int               src_idle_pct  = 0;
    int               snk_idle_pct  = 0;
    int               err_count     = 0;
    int               items_queued  = 0;
    int               points_taken  = 0;
    int               results_seen  = 0;
    int               settings_used = 1;
    int unsigned      longest_run   = 0;

    // ------------------------------------------------------------------------
    // Count predictor
    // ------------------------------------------------------------------------
    function automatic longint coord_sat(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // Exact product, magnitude truncated by FRAC, then clamped to the
    // coordinate range. Operands are always inside the 32-bit range, so the
    // 64-bit product cannot overflow.
    function automatic longint fx_mul(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >>> FRAC;
        if (p < 0) m = -m;
        return coord_sat(m);
    endfunction

    function automatic logic [CNT_W-1:0] escape_count(longint zr0, longint zi0,
                                                      int unsigned limit);
        longint      zr, zi, nr, ni, sq_r, sq_i;
        int unsigned n;
        int unsigned lim;
        bit          escaped;
        zr      = zr0;
        zi      = zi0;
        n       = 0;
        escaped = 1'b0;
        lim     = (limit > CNT_MAX) ? CNT_MAX : limit;
        while (n < lim && !escaped) begin
            sq_r = fx_mul(zr, zr);
            sq_i = fx_mul(zi, zi);
            if (sq_r + sq_i >= FOUR) begin
                escaped = 1'b1;
            end else begin
                // this variant: new_r = zr^2 - (zi*zr)*zi + cr, new_i = new_r*zr + ci
                nr = coord_sat(sq_r - fx_mul(fx_mul(zi, zr), zi) + cfg_c_real);
                ni = coord_sat(fx_mul(nr, zr) + cfg_c_imag);
                zr = nr;
                zi = ni;
                n++;
            end
        end
        return n[CNT_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Driver: new values go out at the falling edge. A point is held until
    // the rising edge that transfers it, then the next one (or a gap) follows.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!drv_valid || pt_taken) begin
            if (pending_points.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_pt    = pending_points.pop_front();
                drv_valid <= 1'b1;
                drv_re    <= next_pt.re;
                drv_im    <= next_pt.im;
            end else begin
                drv_valid <= 1'b0;
            end
        end
        res_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge. An accepted point is
    // predicted against the current register shadow; a count transfer is
    // checked against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            pt_taken <= 1'b0;
        end else begin
            pt_taken <= pt_if.valid && pt_if.ready;
            if (pt_if.valid && pt_if.ready) begin
                expected_counts.push_back(
                    escape_count(pt_if.start_real, pt_if.start_imag, cfg_bound));
                points_taken++;
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: unexpected count transfer: expected none, actual %0d",
                             $time, res_if.iteration_count);
                    err_count++;
                end else begin
                    if (res_if.iteration_count !== expected_counts[0]) begin
                        $display("%0t: iteration_count mismatch: expected %0d, actual %0d",
                                 $time, expected_counts[0], res_if.iteration_count);
                        err_count++;
                    end
                    if (expected_counts[0] > longest_run) longest_run = expected_counts[0];
                    void'(expected_counts.pop_front());
                    results_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [etf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [COORD_W-1:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
        case (idx)
            etf_pkg::CFG_MAX_ITER: cfg_bound  = data[CNT_W-1:0];
            etf_pkg::CFG_C_REAL:   cfg_c_real = longint'(signed'(data));
            etf_pkg::CFG_C_IMAG:   cfg_c_imag = longint'(signed'(data));
            default: ;    // unused index, dropped by the block
        endcase
    endtask

    // Bound write with junk in the upper half; only the low 16 bits count.
    task automatic write_bound(input logic [CNT_W-1:0] bound);
        write_reg(etf_pkg::CFG_MAX_ITER, {16'($urandom), bound});
    endtask

    task automatic push_point(input logic signed [COORD_W-1:0] re,
                              input logic signed [COORD_W-1:0] im);
        pending_points.push_back('{re: re, im: im});
        items_queued++;
    endtask

    // Idle means every queued point has produced its checked count.
    task automatic wait_idle();
        while (results_seen != items_queued) @(negedge clk);
        repeat (4) @(negedge clk);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic signed [COORD_W-1:0] re, im;
        logic [CNT_W-1:0]          bound;
        int                        sel;
        int                        tries;
        bit                        wide_bound;

        // sender idles 23%, receiver 77% for the first third
        src_idle_pct = 23;
        snk_idle_pct = 77;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // --- directed, reset configuration (bound 64, c = 0.84 + 0.31i) ---
        push_point('0, '0);
        push_point(Q_MAX, Q_MAX);
        push_point(Q_MIN, Q_MIN);
        push_point(Q_MAX, Q_MIN);
        push_point(Q_MIN, '0);
        push_point(Q_TWO, '0);              // exactly on the radius: stops at once
        push_point(Q_TWO - 1, '0);          // one step inside the radius
        push_point('0, -Q_TWO);
        push_point(Q_HALF, Q_HALF);
        push_point(-32'sd80530637, 32'sd53687091);

        // write to the undecoded index must leave all settings alone
        wait_idle();
        write_reg(CFG_UNUSED, $urandom);
        push_point(Q_QUART, -Q_QUART);

        // zero bound: every count is 0, even for a point at the origin
        wait_idle();
        write_bound(16'd0);
        push_point('0, '0);
        push_point(32'sd26843546, 32'sd26843546);

        // bound of one
        wait_idle();
        write_bound(16'd1);
        push_point('0, '0);
        push_point(Q_MIN, Q_MIN);

        // c at the corners of the range with the widest bound: the orbit is
        // thrown out of the radius after a single update
        wait_idle();
        write_bound(16'hFFFF);
        write_reg(etf_pkg::CFG_C_REAL, Q_MAX);
        write_reg(etf_pkg::CFG_C_IMAG, Q_MIN);
        push_point('0, '0);
        push_point(Q_ONE, Q_ONE);
        wait_idle();
        write_reg(etf_pkg::CFG_C_REAL, Q_MIN);
        write_reg(etf_pkg::CFG_C_IMAG, Q_MAX);
        push_point('0, '0);
        push_point(-Q_HALF, Q_QUART);

        // --- random phases: a new register setting each, three idle modes ---
        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            case (ph / 3)
                0: begin src_idle_pct = 23; snk_idle_pct = 77; end
                1: begin src_idle_pct = 77; snk_idle_pct = 23; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase

            // only one phase runs the widest bound; its points are screened so
            // that no single orbit runs for tens of thousands of updates
            wide_bound = (ph == 4);
            if (ph == 0) begin
                bound = 16'd64;
            end else if (wide_bound) begin
                bound = 16'hFFFF;
            end else begin
                case ($urandom_range(0, 2))
                    0:       bound = 16'd64;
                    1:       bound = 16'($urandom_range(1, 64));
                    default: bound = 16'($urandom_range(0, 16));
                endcase
            end
            write_bound(bound);

            if (ph == 0) begin
                write_reg(etf_pkg::CFG_C_REAL, C_REAL_RST);
                write_reg(etf_pkg::CFG_C_IMAG, C_IMAG_RST);
            end else if ($urandom_range(0, 3) == 0) begin
                write_reg(etf_pkg::CFG_C_REAL, $urandom);
                write_reg(etf_pkg::CFG_C_IMAG, $urandom);
            end else begin
                // c within +/-1.0 keeps orbits alive for a while
                write_reg(etf_pkg::CFG_C_REAL,
                          $urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
                write_reg(etf_pkg::CFG_C_IMAG,
                          $urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
            end

            for (int k = 0; k < 59; k++) begin
                tries = 0;
                do begin
                    sel = $urandom_range(0, 99);
                    if (sel < 20) begin
                        // noise over the whole coordinate range
                        re = $urandom;
                        im = $urandom;
                    end else if (sel < 35) begin
                        // near the origin, within +/-0.5
                        re = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
                        im = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
                    end else begin
                        // inside the +/-2.0 box around the escape circle
                        re = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
                        im = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
                    end
                    tries++;
                end while (wide_bound && tries < 20 && escape_count(re, im, 101) > 100);
                if (wide_bound && escape_count(re, im, 101) > 100) begin
                    re = Q_MAX;
                    im = $urandom;
                end
                push_point(re, im);
            end
        end

        // drain, then watch a while for stray count transfers
        while (results_seen != items_queued) @(negedge clk);
        repeat (40) @(negedge clk);

        if (expected_counts.size() != 0) begin
            $display("%0t: %0d predicted counts never arrived", $time, expected_counts.size());
            err_count++;
        end

        $display("Ran %0d starting points over %0d register settings, %0d counts checked,",
                 points_taken, settings_used, results_seen);
        $display("longest orbit %0d updates, %0d errors.", longest_run, err_count);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: the slowest legal run stays under a quarter of this.
    initial begin
        #20ms;
        $display("%0t: timeout with %0d counts outstanding", $time, items_queued - results_seen);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/etf_pkg.sv
rtl/etf_in_if.sv
rtl/etf_out_if.sv
rtl/etf_mul.sv
rtl/etf_queue.sv
rtl/etf_front.sv
rtl/etf_back.sv
rtl/escape_time_fractal_iterator.sv
rtl/etf_chk.sv
verif/testbench.sv
